>>> src/ldtp_pkg.sv
// Shared types, constants and the descriptor bit-pop function of the
// LZ descriptor token parser. No dependencies.
`default_nettype none

package ldtp_pkg;

    localparam int DESC_BITS = 16;

    localparam logic [4:0]  DESC_FULL      = 5'd16;
    localparam logic [2:0]  INLINE_LEN_MIN = 3'd2;
    localparam logic [18:0] FULL_DIST_HI   = '1;
    localparam logic [23:0] INLINE_DIST_HI = '1;
    localparam logic [7:0]  DUMMY_LIMIT    = 8'd10;
    localparam logic [7:0]  TERM_COUNT     = 8'd1;

    typedef enum logic [3:0] {
        PH_RELOAD_LO,
        PH_RELOAD_HI,
        PH_LIT,
        PH_FULL1,
        PH_FULL2,
        PH_EXT,
        PH_INLINE,
        PH_TOP,
        PH_POP2,
        PH_POP3,
        PH_POP4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_LITERAL = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_TERM    = 3'd2,
        KIND_DUMMY   = 3'd3,
        KIND_EXT     = 3'd4,
        KIND_INLINE  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] stream_offset;
        logic [31:0] dest_position;
        logic [31:0] source_position;
        logic [7:0]  match_length;
        logic [7:0]  literal_value;
    } result_t;

    typedef struct packed {
        logic [DESC_BITS-1:0] desc;
        logic [4:0]           bits_left;
        phase_t               phase;
        phase_t               resume;
        logic [2:0]           inline_len;
        logic                 cap;
        logic                 cap_reload;
    } pop_t;

    // Pop descriptor bits until a byte is needed or the descriptor runs dry.
    function automatic pop_t run_bits(phase_t p, logic [DESC_BITS-1:0] d,
                                      logic [4:0] bl, logic [2:0] il,
                                      phase_t resume);
        pop_t   r;
        phase_t cur;
        logic   done;
        logic   b;
        int     i;
        r.desc       = d;
        r.bits_left  = bl;
        r.phase      = p;
        r.resume     = resume;
        r.inline_len = il;
        r.cap        = 1'b0;
        r.cap_reload = 1'b0;
        cur          = p;
        done         = 1'b0;
        b            = 1'b0;
        for (i = 0; i < 4; i++)
        begin
            if (!done)
            begin
                case (cur)
                    PH_TOP, PH_POP2, PH_POP3, PH_POP4:
                    begin
                        b      = r.desc[0];
                        r.desc = r.desc >> 1;
                        if (r.bits_left != 5'd0)
                        begin
                            r.bits_left = r.bits_left - 5'd1;
                        end
                    end
                    default:
                    begin
                        b = 1'b0;
                    end
                endcase
                case (cur)
                    PH_TOP:
                    begin
                        if (b)
                        begin
                            r.cap        = 1'b1;
                            r.cap_reload = (r.bits_left == 5'd0);
                            cur          = PH_LIT;
                        end
                        else
                        begin
                            cur = PH_POP2;
                        end
                    end
                    PH_POP2:
                    begin
                        r.cap        = 1'b1;
                        r.cap_reload = (r.bits_left == 5'd0);
                        r.inline_len = INLINE_LEN_MIN;
                        cur          = b ? PH_FULL1 : PH_POP3;
                    end
                    PH_POP3:
                    begin
                        if (b)
                        begin
                            r.inline_len = r.inline_len + 3'd2;
                        end
                        cur = PH_POP4;
                    end
                    PH_POP4:
                    begin
                        if (b)
                        begin
                            r.inline_len = r.inline_len + 3'd1;
                        end
                        cur = PH_INLINE;
                    end
                    default:
                    begin
                        r.phase = cur;
                        done    = 1'b1;
                    end
                endcase
                if (!done && r.bits_left == 5'd0)
                begin
                    r.bits_left = DESC_FULL;
                    r.phase     = PH_RELOAD_LO;
                    r.resume    = cur;
                    done        = 1'b1;
                end
            end
        end
        if (!done)
        begin
            r.phase = cur;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/lz_descriptor_token_parser_unit.sv
// LZ descriptor token parser: one compressed byte per cycle, one record per token.
// Path from byte accept to record valid: input register, then result register.
// Throughput: 1 byte per cycle; decode of each byte is one pass through ldtp_core.
// Input stalls only when the result register is held by the consumer.
// Reset (async, active low) clears all parser state; bytes after a terminator are dropped.
// Depends on ldtp_pkg, ldtp_core, ldtp_out.
`default_nettype none

module lz_descriptor_token_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       token_kind,
    output logic [31:0]      stream_offset,
    output logic [31:0]      dest_position,
    output logic [31:0]      source_position,
    output logic [7:0]       match_length,
    output logic [7:0]       literal_value
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              accept;
    logic              adv;
    logic              free;
    logic              core_valid;
    ldtp_pkg::result_t core_res;
    ldtp_pkg::result_t out_res;

    always_comb
    begin
        adv      = in_valid_reg && free;
        in_stall = in_valid_reg && !free;
        accept   = in_valid && !in_stall;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
        end
    end

    ldtp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .data_byte (in_byte_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    ldtp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && core_valid),
        .res       (core_res),
        .out_stall (out_stall),
        .free      (free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign token_kind      = out_res.kind;
    assign stream_offset   = out_res.stream_offset;
    assign dest_position   = out_res.dest_position;
    assign source_position = out_res.source_position;
    assign match_length    = out_res.match_length;
    assign literal_value   = out_res.literal_value;

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled without a held result");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(stream_offset)))
        else $error("held result lost");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && core_valid) |-> free)
        else $error("result loaded over a held result");

endmodule

`default_nettype wire

>>> src/ldtp_core.sv
// Parser state and single-pass token decode for one stream byte.
// Depends on ldtp_pkg.
`default_nettype none

module ldtp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    output logic                  res_valid,
    output ldtp_pkg::result_t     res
);

    logic [15:0]          desc_reg,        desc_next;
    logic [4:0]           bits_left_reg,   bits_left_next;
    ldtp_pkg::phase_t     phase_reg,       phase_next;
    ldtp_pkg::phase_t     resume_reg,      resume_next;
    logic [7:0]           first_reg,       first_next;
    logic [7:0]           second_reg,      second_next;
    logic [2:0]           inline_len_reg,  inline_len_next;
    logic [31:0]          pos_reg,         pos_next;
    logic [31:0]          offset_reg,      offset_next;
    logic [31:0]          token_start_reg, token_start_next;
    logic                 finished_reg,    finished_next;

    ldtp_pkg::phase_t     run_p;
    logic [15:0]          run_d;
    logic [4:0]           run_bl;
    ldtp_pkg::pop_t       pop;
    logic                 do_run;
    logic [7:0]           sec;
    logic [7:0]           count;
    logic [7:0]           adv_len;
    logic [31:0]          full_src;
    logic [31:0]          inline_src;

    always_comb
    begin
        offset_next = offset_reg + 32'd1;
        count       = data_byte + 8'd1;
        sec         = (phase_reg == ldtp_pkg::PH_FULL2) ? data_byte : second_reg;
        full_src    = pos_reg + {ldtp_pkg::FULL_DIST_HI, sec[7:3], first_reg};
        inline_src  = pos_reg + {ldtp_pkg::INLINE_DIST_HI, data_byte};

        if (phase_reg == ldtp_pkg::PH_RELOAD_HI)
        begin
            run_p  = resume_reg;
            run_d  = {data_byte, desc_reg[7:0]};
            run_bl = ldtp_pkg::DESC_FULL;
        end
        else
        begin
            run_p  = ldtp_pkg::PH_TOP;
            run_d  = desc_reg;
            run_bl = bits_left_reg;
        end
        pop = ldtp_pkg::run_bits(run_p, run_d, run_bl, inline_len_reg, resume_reg);

        desc_next        = desc_reg;
        bits_left_next   = bits_left_reg;
        phase_next       = phase_reg;
        resume_next      = resume_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        inline_len_next  = inline_len_reg;
        finished_next    = finished_reg;
        do_run           = 1'b0;
        adv_len          = 8'd0;

        res_valid           = 1'b0;
        res.kind            = ldtp_pkg::KIND_LITERAL;
        res.stream_offset   = token_start_reg;
        res.dest_position   = pos_reg;
        res.source_position = 32'd0;
        res.match_length    = 8'd0;
        res.literal_value   = 8'd0;

        case (phase_reg)
            ldtp_pkg::PH_RELOAD_LO:
            begin
                desc_next  = {8'd0, data_byte};
                phase_next = ldtp_pkg::PH_RELOAD_HI;
            end
            ldtp_pkg::PH_RELOAD_HI:
            begin
                do_run = 1'b1;
            end
            ldtp_pkg::PH_LIT:
            begin
                res_valid         = 1'b1;
                res.match_length  = 8'd1;
                res.literal_value = data_byte;
                adv_len           = 8'd1;
                do_run            = 1'b1;
            end
            ldtp_pkg::PH_FULL1:
            begin
                first_next = data_byte;
                phase_next = ldtp_pkg::PH_FULL2;
            end
            ldtp_pkg::PH_FULL2:
            begin
                second_next = data_byte;
                if (data_byte[2:0] != 3'd0)
                begin
                    res_valid           = 1'b1;
                    res.kind            = ldtp_pkg::KIND_FULL;
                    res.source_position = full_src;
                    res.match_length    = {5'd0, data_byte[2:0]} + 8'd2;
                    adv_len             = res.match_length;
                    do_run              = 1'b1;
                end
                else
                begin
                    phase_next = ldtp_pkg::PH_EXT;
                end
            end
            ldtp_pkg::PH_EXT:
            begin
                res_valid           = 1'b1;
                res.source_position = full_src;
                if (count == ldtp_pkg::TERM_COUNT)
                begin
                    res.kind      = ldtp_pkg::KIND_TERM;
                    finished_next = 1'b1;
                end
                else
                begin
                    res.kind = (count < ldtp_pkg::DUMMY_LIMIT) ? ldtp_pkg::KIND_DUMMY
                                                               : ldtp_pkg::KIND_EXT;
                    res.match_length = count;
                    adv_len          = count;
                    do_run           = 1'b1;
                end
            end
            ldtp_pkg::PH_INLINE:
            begin
                res_valid           = 1'b1;
                res.kind            = ldtp_pkg::KIND_INLINE;
                res.source_position = inline_src;
                res.match_length    = {5'd0, inline_len_reg};
                adv_len             = res.match_length;
                do_run              = 1'b1;
            end
            default:
            begin
                do_run = 1'b1;
            end
        endcase

        pos_next         = pos_reg + {24'd0, adv_len};
        token_start_next = token_start_reg;
        if (do_run)
        begin
            desc_next       = pop.desc;
            bits_left_next  = pop.bits_left;
            phase_next      = pop.phase;
            resume_next     = pop.resume;
            inline_len_next = pop.inline_len;
            if (pop.cap)
            begin
                token_start_next = offset_next + {30'd0, pop.cap_reload, 1'b0};
            end
        end

        if (finished_reg)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg        <= '0;
            bits_left_reg   <= ldtp_pkg::DESC_FULL;
            phase_reg       <= ldtp_pkg::PH_RELOAD_LO;
            resume_reg      <= ldtp_pkg::PH_TOP;
            first_reg       <= '0;
            second_reg      <= '0;
            inline_len_reg  <= ldtp_pkg::INLINE_LEN_MIN;
            pos_reg         <= '0;
            offset_reg      <= '0;
            token_start_reg <= '0;
            finished_reg    <= 1'b0;
        end
        else if (step && !finished_reg)
        begin
            desc_reg        <= desc_next;
            bits_left_reg   <= bits_left_next;
            phase_reg       <= phase_next;
            resume_reg      <= resume_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            inline_len_reg  <= inline_len_next;
            pos_reg         <= pos_next;
            offset_reg      <= offset_next;
            token_start_reg <= token_start_next;
            finished_reg    <= finished_next;
        end
    end

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !res_valid)
        else $error("result raised after terminator");

    a_done_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (step && finished_reg) |=> $stable(offset_reg) && $stable(pos_reg))
        else $error("state moved after terminator");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg != 5'd0 && bits_left_reg <= ldtp_pkg::DESC_FULL)
        else $error("descriptor bit count out of range");

    a_term_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == ldtp_pkg::KIND_TERM) |->
            (res.match_length == 8'd0 && res.literal_value == 8'd0))
        else $error("terminator with nonzero length");

endmodule

`default_nettype wire

>>> src/ldtp_out.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on ldtp_pkg.
`default_nettype none

module ldtp_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ldtp_pkg::result_t res,
    input  wire logic              out_stall,
    output logic                   free,
    output logic                   out_valid,
    output ldtp_pkg::result_t      out_res
);

    logic              valid_reg, valid_next;
    ldtp_pkg::result_t res_reg;

    always_comb
    begin
        free       = !valid_reg || !out_stall;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
